/* src/i2cblm_pkg.sv */
// types, constants and phase decode shared by the i2c bit-level master
package i2cblm_pkg;

  localparam int unsigned TICK_W    = 16;
  localparam int unsigned PHASE_W   = 5;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BYTE_TOP  = 7;
  localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd100;

  localparam logic [PHASE_W-1:0] PHASES_SHORT = 5'd2;
  localparam logic [PHASE_W-1:0] PHASES_WRITE = 5'd27;
  localparam logic [PHASE_W-1:0] PHASES_READ  = 5'd20;
  localparam logic [PHASE_W-1:0] WR_DATA_END  = 5'd24;
  localparam logic [PHASE_W-1:0] WR_ACK_SCL   = 5'd25;
  localparam logic [PHASE_W-1:0] RD_BITS_END  = 5'd16;
  localparam logic [PHASE_W-1:0] RD_ACK_SDA   = 5'd17;
  localparam logic [PHASE_W-1:0] RD_ACK_SCL   = 5'd18;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_STOP  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_type_t;

  typedef struct packed {
    logic              cmd_valid;
    logic [1:0]        req_type;
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              sda_in;
  } in_data_t;

  typedef struct packed {
    logic              sda_pull_low;
    logic              scl_pull_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              nack_seen;
  } out_data_t;

  typedef struct packed {
    logic sda;
    logic scl;
  } pins_t;

  function automatic logic [PHASE_W-1:0] phase_count(req_type_t cmd);
    case (cmd)
      REQ_WRITE: phase_count = PHASES_WRITE;
      REQ_READ:  phase_count = PHASES_READ;
      default:   phase_count = PHASES_SHORT;
    endcase
  endfunction

  function automatic logic phase_samples(req_type_t cmd, logic [PHASE_W-1:0] p);
    case (cmd)
      REQ_WRITE: phase_samples = (p == WR_ACK_SCL);
      REQ_READ:  phase_samples = (p != '0) && (p <= RD_BITS_END) && p[0];
      default:   phase_samples = 1'b0;
    endcase
  endfunction

  // p / 3 for p below 24 as (p * 11) >> 5
  function automatic pins_t apply_phase(req_type_t cmd, logic [PHASE_W-1:0] p,
                                        logic [BYTE_W-1:0] shift, logic ack,
                                        pins_t cur);
    logic [9:0] prod;
    logic [2:0] grp;
    logic [4:0] sub;
    pins_t      res;
    prod = 10'(p) * 10'd11;
    grp  = prod[7:5];
    sub  = p - 5'(grp) * 5'd3;
    res  = cur;
    case (cmd)
      REQ_START: begin
        if (p == '0) res.sda = 1'b1;
        else res.scl = 1'b1;
      end
      REQ_STOP: begin
        if (p == '0) res.scl = 1'b0;
        else res.sda = 1'b0;
      end
      REQ_WRITE: begin
        if (p < WR_DATA_END) begin
          if (sub == 5'd0) res.sda = ~shift[3'(BYTE_TOP) - grp];
          else if (sub == 5'd1) res.scl = 1'b0;
          else res.scl = 1'b1;
        end else if (p == WR_DATA_END) begin
          res.sda = 1'b0;
        end else if (p == WR_ACK_SCL) begin
          res.scl = 1'b0;
        end else begin
          res.scl = 1'b1;
        end
      end
      default: begin
        if (p == '0) res.sda = 1'b0;
        else if (p <= RD_BITS_END) res.scl = ~p[0];
        else if (p == RD_ACK_SDA) res.sda = ack;
        else if (p == RD_ACK_SCL) res.scl = 1'b0;
        else res.scl = 1'b1;
      end
    endcase
    return res;
  endfunction

endpackage

/* src/i2c_bit_level_master.sv */
// i2c bit-level master: one request is one clock tick of the pin sequencer
//
// Each request is one tick of an open-drain I2C master; every request yields
// one result carrying the pin drives, busy, done, the last read byte and the
// last ack sample. A request is taken every cycle: the sequencer state and the
// result register load in the same cycle, and a request is accepted whenever
// the result register is empty or being taken. Commands: start, stop, write
// byte (ack sampled into nack_seen), read byte (ack or nack driven per
// send_ack). Every pin phase lasts cfg_wdata ticks as last written (zero acts
// as one); a command offered while busy is ignored.
module i2c_bit_level_master (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  i2cblm_pkg::in_data_t         in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output i2cblm_pkg::out_data_t        out_data,
  input  logic                         cfg_we,
  input  logic [i2cblm_pkg::TICK_W-1:0] cfg_wdata
);
  import i2cblm_pkg::*;

  logic [TICK_W-1:0]  phase_ticks_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt, phase_inc;
  logic [TICK_W-1:0]  div_r, div_nxt, div_inc, limit;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic [BYTE_W-1:0]  rx_r, rx_nxt;
  req_type_t          cmd_r, cmd_nxt;
  logic               ack_r, ack_nxt;
  pins_t              pins_r, pins_nxt;
  logic               busy_r, busy_nxt;
  logic               nack_r, nack_nxt;
  logic               done;
  logic               in_fire;
  logic               out_valid_r;
  out_data_t          out_data_r;

  assign in_ready  = ~out_valid_r | out_ready;
  assign in_fire   = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign limit     = (phase_ticks_r == '0) ? TICK_W'(1) : phase_ticks_r;

  always_comb begin
    cmd_nxt   = cmd_r;
    ack_nxt   = ack_r;
    shift_nxt = shift_r;
    phase_nxt = phase_r;
    div_nxt   = div_r;
    busy_nxt  = busy_r;
    pins_nxt  = pins_r;
    nack_nxt  = nack_r;
    rx_nxt    = rx_r;
    done      = 1'b0;
    div_inc   = '0;
    phase_inc = '0;
    if (!busy_r && in_data.cmd_valid) begin
      cmd_nxt   = req_type_t'(in_data.req_type);
      ack_nxt   = in_data.send_ack;
      shift_nxt = (cmd_nxt == REQ_WRITE) ? in_data.tx_byte : '0;
      phase_nxt = '0;
      div_nxt   = '0;
      busy_nxt  = 1'b1;
      pins_nxt  = apply_phase(cmd_nxt, '0, shift_nxt, ack_nxt, pins_r);
    end
    if (busy_nxt) begin
      div_inc = div_nxt + TICK_W'(1);
      if (div_inc >= limit) begin
        if (phase_samples(cmd_nxt, phase_nxt)) begin
          if (cmd_nxt == REQ_WRITE) nack_nxt = in_data.sda_in;
          else shift_nxt = {shift_nxt[BYTE_W-2:0], in_data.sda_in};
        end
        div_nxt   = '0;
        phase_inc = phase_nxt + PHASE_W'(1);
        if (phase_inc >= phase_count(cmd_nxt)) begin
          if (cmd_nxt == REQ_READ) rx_nxt = shift_nxt;
          busy_nxt  = 1'b0;
          phase_nxt = '0;
          done      = 1'b1;
        end else begin
          phase_nxt = phase_inc;
          pins_nxt  = apply_phase(cmd_nxt, phase_inc, shift_nxt, ack_nxt, pins_nxt);
        end
      end else begin
        div_nxt = div_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      phase_ticks_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= REQ_START;
      ack_r   <= 1'b0;
      shift_r <= '0;
      phase_r <= '0;
      div_r   <= '0;
      busy_r  <= 1'b0;
      pins_r  <= '0;
      nack_r  <= 1'b0;
      rx_r    <= '0;
    end else if (in_fire) begin
      cmd_r   <= cmd_nxt;
      ack_r   <= ack_nxt;
      shift_r <= shift_nxt;
      phase_r <= phase_nxt;
      div_r   <= div_nxt;
      busy_r  <= busy_nxt;
      pins_r  <= pins_nxt;
      nack_r  <= nack_nxt;
      rx_r    <= rx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.sda_pull_low <= pins_nxt.sda;
      out_data_r.scl_pull_low <= pins_nxt.scl;
      out_data_r.busy_res     <= busy_nxt;
      out_data_r.done_res     <= done;
      out_data_r.rx_byte      <= rx_nxt;
      out_data_r.nack_seen    <= nack_nxt;
    end
  end

endmodule
